@@ hdl/postfix_stack_evaluator_unit_defines.svh @@
// Assertion macros for the postfix evaluator.
`ifndef POSTFIX_STACK_EVALUATOR_UNIT_DEFINES_SVH
`define POSTFIX_STACK_EVALUATOR_UNIT_DEFINES_SVH

// Same-cycle implication, clocked on aclk, off during reset.
`define PSE_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on aclk, off during reset.
`define PSE_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/pse_pkg.sv @@
// Constants and codes for the postfix evaluator.
`default_nettype none
package pse_pkg;
    localparam int STACK_DEPTH = 64;
    localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int VALUE_W     = 32;
    localparam int STATUS_W    = 3;
    localparam int CHAR_W      = 8;
    localparam int OUT_TDATA_W = 40;

    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_MUL   = 8'h2A;
    localparam logic [CHAR_W-1:0] CHAR_DIV   = 8'h2F;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_INVALID   = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_UNDERFLOW = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_DIVZERO   = 3'd4;

    typedef logic [VALUE_W-1:0] value_t;
endpackage
`default_nettype wire

@@ hdl/postfix_stack_evaluator_unit.sv @@
// Postfix (RPN) expression evaluator with a RAM-backed operand stack.
//
// Input beats carry one ASCII character each on s_tdata; s_tlast marks the
// last character of an expression. Digits push, + - * / pop two and push
// the result (wrapping arithmetic, division truncates toward zero).
// On the last beat one result beat leaves on m_tdata: the top of stack and
// a status (ok, invalid char, underflow, overflow, divide by zero; value 0
// on error). The first error is held until the end of the expression, and
// the stack is then emptied.
// One character is processed at a time: a digit or an invalid character
// is decoded and finished, + - * add an execute step (stack RAM read, then
// the ALU), and / also runs the restoring divider and a sign fix-up.
// The result sits in an output register; the next character is accepted
// while it waits. If a further result is due before it is taken, the block
// holds in its final state until m_tready frees the register.
// Reset (aresetn low, synchronous) empties the stack, clears the error and
// drops m_tvalid. The stack RAM needs no clearing.
`default_nettype none
`include "postfix_stack_evaluator_unit_defines.svh"
module postfix_stack_evaluator_unit (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [pse_pkg::CHAR_W-1:0]          s_tdata,  // [7:0] symbol_char
    input  wire logic                                s_tlast,  // end_of_expression
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [pse_pkg::OUT_TDATA_W-1:0]          m_tdata   // [31:0] result_value,
                                                               // [34:32] status, zero pad
);
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DEC  = 3'd1;
    localparam logic [2:0] ST_EXEC = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_DFIX = 3'd4;
    localparam logic [2:0] ST_FIN  = 3'd5;

    localparam int DW = pse_pkg::DEPTH_W;
    localparam int AW = pse_pkg::ADDR_W;
    localparam int VW = pse_pkg::VALUE_W;

    logic [2:0]                     state_reg, state_next;
    logic [DW-1:0]                  depth_reg, depth_next;
    logic [pse_pkg::STATUS_W-1:0]   err_reg, err_next;
    pse_pkg::value_t                tos_reg, tos_next;
    logic [pse_pkg::CHAR_W-1:0]     char_reg, char_next;
    logic                           last_reg, last_next;
    logic [VW-1:0]                  rem_reg, rem_next;
    pse_pkg::value_t                quot_reg, quot_next;
    pse_pkg::value_t                dvsr_reg, dvsr_next;
    logic                           neg_reg, neg_next;
    logic [4:0]                     cnt_reg, cnt_next;
    logic                           m_tvalid_reg, m_tvalid_next;
    pse_pkg::value_t                m_value_reg, m_value_next;
    logic [pse_pkg::STATUS_W-1:0]   m_status_reg, m_status_next;

    pse_pkg::value_t                stack_mem [pse_pkg::STACK_DEPTH];
    pse_pkg::value_t                rd_data_reg;
    logic [AW-1:0]                  rd_addr;
    logic [AW-1:0]                  wr_addr;
    logic                           mem_we;

    pse_pkg::value_t                op_a;
    pse_pkg::value_t                op_b;
    logic [VW:0]                    rem_shift;
    logic [VW:0]                    rem_sub;
    logic                           out_free;

    assign rd_addr   = AW'(depth_reg - DW'(2));
    assign wr_addr   = AW'(depth_reg - DW'(1));
    assign op_a      = rd_data_reg;
    assign op_b      = tos_reg;
    assign rem_shift = {rem_reg, quot_reg[VW-1]};
    assign rem_sub   = rem_shift - {1'b0, dvsr_reg};
    assign out_free  = !m_tvalid_reg || m_tready;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(pse_pkg::OUT_TDATA_W - VW - pse_pkg::STATUS_W){1'b0}},
                       m_status_reg, m_value_reg};

    // stack RAM: entries below the top; the top lives in tos_reg
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            stack_mem[wr_addr] <= tos_reg;
        end
        rd_data_reg <= stack_mem[rd_addr];
    end

    always_comb begin
        state_next    = state_reg;
        depth_next    = depth_reg;
        err_next      = err_reg;
        tos_next      = tos_reg;
        char_next     = char_reg;
        last_next     = last_reg;
        rem_next      = rem_reg;
        quot_next     = quot_reg;
        dvsr_next     = dvsr_reg;
        neg_next      = neg_reg;
        cnt_next      = cnt_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_value_next  = m_value_reg;
        m_status_next = m_status_reg;
        mem_we        = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    char_next  = s_tdata;
                    last_next  = s_tlast;
                    state_next = ST_DEC;
                end
            end
            ST_DEC: begin
                state_next = ST_FIN;
                if (err_reg == pse_pkg::STATUS_OK) begin
                    if (char_reg inside {[pse_pkg::CHAR_ZERO:pse_pkg::CHAR_NINE]}) begin
                        if (depth_reg == DW'(pse_pkg::STACK_DEPTH)) begin
                            err_next = pse_pkg::STATUS_OVERFLOW;
                        end else begin
                            mem_we     = (depth_reg != '0);
                            tos_next   = VW'(char_reg - pse_pkg::CHAR_ZERO);
                            depth_next = depth_reg + DW'(1);
                        end
                    end else if (char_reg inside {pse_pkg::CHAR_PLUS, pse_pkg::CHAR_MINUS,
                                                  pse_pkg::CHAR_MUL, pse_pkg::CHAR_DIV}) begin
                        if (depth_reg < DW'(2)) begin
                            err_next = pse_pkg::STATUS_UNDERFLOW;
                        end else begin
                            state_next = ST_EXEC;
                        end
                    end else begin
                        err_next = pse_pkg::STATUS_INVALID;
                    end
                end
            end
            ST_EXEC: begin
                state_next = ST_FIN;
                case (char_reg)
                    pse_pkg::CHAR_PLUS: begin
                        tos_next   = op_a + op_b;
                        depth_next = depth_reg - DW'(1);
                    end
                    pse_pkg::CHAR_MINUS: begin
                        tos_next   = op_a - op_b;
                        depth_next = depth_reg - DW'(1);
                    end
                    pse_pkg::CHAR_MUL: begin
                        tos_next   = op_a * op_b;
                        depth_next = depth_reg - DW'(1);
                    end
                    default: begin
                        if (op_b == '0) begin
                            err_next = pse_pkg::STATUS_DIVZERO;
                        end else begin
                            rem_next   = '0;
                            quot_next  = op_a[VW-1] ? (~op_a + VW'(1)) : op_a;
                            dvsr_next  = op_b[VW-1] ? (~op_b + VW'(1)) : op_b;
                            neg_next   = op_a[VW-1] ^ op_b[VW-1];
                            cnt_next   = '1;
                            state_next = ST_DIV;
                        end
                    end
                endcase
            end
            ST_DIV: begin
                // restoring division, one quotient bit per cycle
                if (!rem_sub[VW]) begin
                    rem_next  = rem_sub[VW-1:0];
                    quot_next = {quot_reg[VW-2:0], 1'b1};
                end else begin
                    rem_next  = rem_shift[VW-1:0];
                    quot_next = {quot_reg[VW-2:0], 1'b0};
                end
                cnt_next = cnt_reg - 5'd1;
                if (cnt_reg == '0) begin
                    state_next = ST_DFIX;
                end
            end
            ST_DFIX: begin
                tos_next   = neg_reg ? (~quot_reg + VW'(1)) : quot_reg;
                depth_next = depth_reg - DW'(1);
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (!last_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    m_tvalid_next = 1'b1;
                    if (err_reg != pse_pkg::STATUS_OK) begin
                        m_status_next = err_reg;
                        m_value_next  = '0;
                    end else if (depth_reg == '0) begin
                        m_status_next = pse_pkg::STATUS_UNDERFLOW;
                        m_value_next  = '0;
                    end else begin
                        m_status_next = pse_pkg::STATUS_OK;
                        m_value_next  = tos_reg;
                    end
                    depth_next = '0;
                    err_next   = pse_pkg::STATUS_OK;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            depth_reg    <= '0;
            err_reg      <= pse_pkg::STATUS_OK;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            depth_reg    <= depth_next;
            err_reg      <= err_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        tos_reg      <= tos_next;
        char_reg     <= char_next;
        last_reg     <= last_next;
        rem_reg      <= rem_next;
        quot_reg     <= quot_next;
        dvsr_reg     <= dvsr_next;
        neg_reg      <= neg_next;
        cnt_reg      <= cnt_next;
        m_value_reg  <= m_value_next;
        m_status_reg <= m_status_next;
    end

    `PSE_ASSERT_NOW(a_depth_bound, 1'b1,
        depth_reg <= DW'(pse_pkg::STACK_DEPTH), "stack depth out of range")
    `PSE_ASSERT_NOW(a_err_value_zero,
        m_tvalid_reg && (m_status_reg != pse_pkg::STATUS_OK),
        m_value_reg == '0, "non-zero value with error status")
    `PSE_ASSERT_NEXT(a_end_clears, (state_reg == ST_FIN) && last_reg && out_free,
        (depth_reg == '0) && (err_reg == pse_pkg::STATUS_OK) && m_tvalid_reg,
        "expression end did not clear stack")
    `PSE_ASSERT_NEXT(a_div_done, (state_reg == ST_DIV) && (cnt_reg == '0),
        state_reg == ST_DFIX, "divider did not finish")
endmodule
`default_nettype wire
